### sv/fsdf_pkg.sv
// ----------------------------------------------------------------------------
// fsdf_pkg
// Shared types and constants for the feed sequence filter.
// ----------------------------------------------------------------------------
package fsdf_pkg;

	localparam int SEGMENTS = 16;
	localparam int IDX_W    = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CNT_W    = $clog2(SEGMENTS + 1);
	localparam int KEY_W    = 32;
	localparam int SEQ_W    = 32;

	localparam logic [15:0] TEMPLATE_RESET = 16'd13002;

	typedef enum logic [2:0] {
		V_NEW            = 3'd0,
		V_SNAPSHOT       = 3'd1,
		V_STALE          = 3'd2,
		V_BAD_TEMPLATE   = 3'd3,
		V_UNKNOWN_SOURCE = 3'd4,
		V_TABLE_FULL     = 3'd5
	} fsdf_verdict_t;

	typedef struct packed {
		logic               from_known_source;
		logic [15:0]        template_id;
		logic signed [31:0] segment_id;
		logic [31:0]        sequence_number;
		logic [15:0]        receive_port;
	} fsdf_in_t;

	typedef struct packed {
		logic          forward;
		fsdf_verdict_t verdict;
	} fsdf_out_t;

	typedef struct packed {
		logic      valid;
		fsdf_out_t data;
	} fsdf_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} fsdf_state_t;

endpackage

### sv/fsdf_ram.sv
// ----------------------------------------------------------------------------
// fsdf_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fsdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### sv/fsdf_engine.sv
// ----------------------------------------------------------------------------
// fsdf_engine
// Filter sequencer: source and template checks, linear key search over the
// segment table, sequence check and write-back.
// ----------------------------------------------------------------------------
module fsdf_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         accepted_template,
	input  logic                in_valid,
	output logic                in_ready,
	input  fsdf_pkg::fsdf_in_t  in_data,
	input  logic                res_free,
	output fsdf_pkg::fsdf_res_t res
);
	import fsdf_pkg::*;

	fsdf_state_t state_q, state_d;
	fsdf_in_t    item_q;
	fsdf_out_t   res_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] used_q;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [KEY_W-1:0] key_rd;
	logic [SEQ_W-1:0] seq_rd;

	logic scanning, accept, issue, match, miss, full, odd, stale_hit, new_ok;
	logic             key_we, seq_we;
	logic [IDX_W-1:0] seq_waddr;
	logic [SEQ_W-1:0] seq_wdata;
	fsdf_out_t        early_res, scan_res;

	fsdf_ram #(.WIDTH(KEY_W), .DEPTH(SEGMENTS)) u_key_ram (
		.clk     (clk),
		.wr_en   (key_we),
		.wr_addr (used_q[IDX_W-1:0]),
		.wr_data ($unsigned(item_q.segment_id)),
		.rd_addr (iss_q[IDX_W-1:0]),
		.rd_data (key_rd)
	);

	fsdf_ram #(.WIDTH(SEQ_W), .DEPTH(SEGMENTS)) u_seq_ram (
		.clk     (clk),
		.wr_en   (seq_we),
		.wr_addr (seq_waddr),
		.wr_data (seq_wdata),
		.rd_addr (iss_q[IDX_W-1:0]),
		.rd_data (seq_rd)
	);

	// outputs of the state machine
	always_comb begin
		in_ready = 1'b0;
		scanning = 1'b0;
		res.valid = 1'b0;
		res.data = res_q;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: scanning = 1'b1;
			ST_EMIT: res.valid = 1'b1;
			default: ;
		endcase
	end

	assign accept    = in_valid && in_ready;
	assign issue     = scanning && (iss_q < used_q);
	assign match     = scanning && chk_s1 && (key_rd == $unsigned(item_q.segment_id));
	assign miss      = scanning && !chk_s1 && !issue;
	assign full      = (used_q == CNT_W'(SEGMENTS));
	assign odd       = item_q.receive_port[0];
	assign stale_hit = (seq_rd >= item_q.sequence_number);
	assign new_ok    = (item_q.sequence_number != '0);

	always_comb begin
		early_res.forward = 1'b0;
		early_res.verdict = V_BAD_TEMPLATE;
		if (!in_data.from_known_source) begin
			early_res.verdict = V_UNKNOWN_SOURCE;
		end
	end

	always_comb begin
		scan_res.forward = 1'b1;
		scan_res.verdict = V_SNAPSHOT;
		key_we    = 1'b0;
		seq_we    = 1'b0;
		seq_waddr = used_q[IDX_W-1:0];
		seq_wdata = '0;
		if (match) begin
			seq_waddr = idx_s1;
			if (odd) begin
				if (stale_hit) begin
					scan_res.forward = 1'b0;
					scan_res.verdict = V_STALE;
				end else begin
					scan_res.verdict = V_NEW;
					seq_we    = 1'b1;
					seq_wdata = item_q.sequence_number;
				end
			end
		end else if (miss) begin
			if (full) begin
				scan_res.verdict = V_TABLE_FULL;
			end else begin
				key_we = 1'b1;
				seq_we = 1'b1;
				if (odd) begin
					if (new_ok) begin
						scan_res.verdict = V_NEW;
						seq_wdata = item_q.sequence_number;
					end else begin
						scan_res.forward = 1'b0;
						scan_res.verdict = V_STALE;
					end
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_data.from_known_source &&
					    (in_data.template_id == accepted_template)) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				if (match || miss) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			chk_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			chk_s1  <= issue;
			if (miss && !full) begin
				used_q <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IDX_W-1:0];
		if (accept) begin
			item_q <= in_data;
			res_q  <= early_res;
			iss_q  <= '0;
		end else if (issue) begin
			iss_q <= iss_q + CNT_W'(1);
		end
		if (match || miss) begin
			res_q <= scan_res;
		end
	end

endmodule

### sv/feed_sequence_dedup_filter_core.sv
// ----------------------------------------------------------------------------
// feed_sequence_dedup_filter_core
// Sequence filter for A/B market data feeds with a per-segment table.
// ----------------------------------------------------------------------------
// One packet header is taken per transaction and exactly one verdict comes
// back. Headers from an unknown source or with a template other than
// accepted_template skip the table search. Others walk the segment table one
// entry per cycle through the key and sequence RAMs (one read port each,
// registered read). The verdict sits in an output register, and a new
// header is taken as soon as the previous one has been handed over.
// The segment table needs no clearing after reset: entries fill in order
// and a fill count marks the valid ones.
module feed_sequence_dedup_filter_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  fsdf_pkg::fsdf_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fsdf_pkg::fsdf_out_t out_data
);
	import fsdf_pkg::*;

	logic [15:0] tmpl_q;
	logic        out_valid_q;
	fsdf_out_t   out_q;
	fsdf_res_t   res;
	logic        res_free;

	assign res_free = !out_valid_q || out_ready;

	fsdf_engine u_engine (
		.clk               (clk),
		.arst_n            (arst_n),
		.accepted_template (tmpl_q),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.in_data           (in_data),
		.res_free          (res_free),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmpl_q      <= TEMPLATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tmpl_q <= cfg_wr_data;
			end
			if (res_free) begin
				out_valid_q <= res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res.valid) begin
			out_q <= res.data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### test/fsdf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsdf_checker
// Watches both channels of the feed sequence filter, predicts every verdict
// from the headers it sees accepted and compares each returned verdict,
// field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module fsdf_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  fsdf_pkg::fsdf_in_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  fsdf_pkg::fsdf_out_t out_data,
	output int                  fail_count,
	output int                  verdicts_owed
);
	import fsdf_pkg::*;

	logic [15:0]      want_template;
	logic [KEY_W-1:0] seg_key  [SEGMENTS];
	logic [SEQ_W-1:0] seg_last [SEGMENTS];
	logic             seg_live [SEGMENTS];
	int               seg_fill;
	fsdf_out_t        owed_q [$];
	fsdf_out_t        owed;

	initial begin
		fail_count    = 0;
		verdicts_owed = 0;
	end

	// Source, then template, then table lookup, then port parity, then sequence.
	function automatic fsdf_out_t judge_packet(input fsdf_in_t p);
		fsdf_out_t r;
		int        hit;
		hit = -1;
		if (!p.from_known_source) begin
			r.forward = 1'b0;
			r.verdict = V_UNKNOWN_SOURCE;
		end else if (p.template_id != want_template) begin
			r.forward = 1'b0;
			r.verdict = V_BAD_TEMPLATE;
		end else begin
			for (int i = 0; i < SEGMENTS; i++) begin
				if (hit < 0 && seg_live[i] && seg_key[i] == $unsigned(p.segment_id))
					hit = i;
			end
			if (hit < 0 && seg_fill < SEGMENTS) begin
				hit           = seg_fill;
				seg_key[hit]  = $unsigned(p.segment_id);
				seg_last[hit] = '0;
				seg_live[hit] = 1'b1;
				seg_fill++;
			end
			if (hit < 0) begin
				r.forward = 1'b1;
				r.verdict = V_TABLE_FULL;
			end else if (!p.receive_port[0]) begin
				r.forward = 1'b1;
				r.verdict = V_SNAPSHOT;
			end else if (seg_last[hit] >= p.sequence_number) begin
				r.forward = 1'b0;
				r.verdict = V_STALE;
			end else begin
				seg_last[hit] = p.sequence_number;
				r.forward     = 1'b1;
				r.verdict     = V_NEW;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_template = TEMPLATE_RESET;
			for (int i = 0; i < SEGMENTS; i++)
				seg_live[i] = 1'b0;
			seg_fill = 0;
			owed_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$error("verdict with none owed: forward %0b verdict %0d",
						out_data.forward, out_data.verdict);
					fail_count++;
				end else begin
					owed = owed_q.pop_front();
					if (out_data.forward !== owed.forward) begin
						$error("forward: expected %0b, actual %0b",
							owed.forward, out_data.forward);
						fail_count++;
					end
					if (out_data.verdict !== owed.verdict) begin
						$error("verdict: expected %0d, actual %0d",
							owed.verdict, out_data.verdict);
						fail_count++;
					end
				end
			end
			if (cfg_wr_en)
				want_template = cfg_wr_data;
			if (in_valid && in_ready)
				owed_q.insert(owed_q.size(), judge_packet(in_data));
		end
		verdicts_owed = owed_q.size();
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the feed sequence filter: directed headers on the corner
// cases, then phases of random A/B feed traffic under several accepted
// templates, with random gaps on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
	import fsdf_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 330;
	localparam int PHASES       = 5;
	localparam int SETTLE       = SEGMENTS + 4;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [15:0] cfg_wr_data = TEMPLATE_RESET;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	fsdf_in_t    in_data     = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	fsdf_out_t   out_data;

	int          fail_count;
	int          verdicts_owed;
	int          quiet;
	bit          calm = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	feed_sequence_dedup_filter_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	fsdf_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.verdicts_owed(verdicts_owed)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet <= 0;
		else if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin : watchdog
		wait (quiet >= QUIET_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random hold-off per verdict, one long stall to back up the input.
	initial begin : sink
		int gap;
		int taken;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 500)
				gap = 400;
			else if (calm)
				gap = 0;
			else
				gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk) out_ready <= 1'b1;
			end else if (!out_ready) begin
				@(negedge clk) out_ready <= 1'b1;
			end
			do @(posedge clk); while (!(out_valid && out_ready));
			taken++;
		end
	end

	task automatic offer_header(input logic known, input logic [15:0] tmpl,
			input logic [31:0] seg, input logic [31:0] seq, input logic [15:0] port);
		fsdf_in_t hdr;
		int       gap;
		hdr.from_known_source = known;
		hdr.template_id       = tmpl;
		hdr.segment_id        = seg;
		hdr.sequence_number   = seq;
		hdr.receive_port      = port;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= hdr;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_all();
		@(negedge clk) in_valid <= 1'b0;
		while (verdicts_owed != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_template(input logic [15:0] v);
		drain_all();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk) cfg_wr_en <= 1'b0;
	endtask

	initial begin : stim
		logic [31:0] pool_key [SEGMENTS];
		logic [31:0] pool_seq [SEGMENTS];
		logic [15:0] phase_tmpl [PHASES];
		logic [15:0] cur_tmpl;
		logic [15:0] port;
		int          roll;
		int          sub;
		int          k;
		int          sent;

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		cur_tmpl = TEMPLATE_RESET;
		// Directed: check order, new entry at zero, equal and older sequences,
		// snapshot leaves the stored sequence, key and sequence extremes.
		offer_header(1'b0, cur_tmpl, 32'h0000_0000, 32'd5, 16'd1);
		offer_header(1'b0, 16'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'd0);
		offer_header(1'b1, 16'h0000, 32'h0000_0000, 32'd9, 16'd1);
		offer_header(1'b1, 16'hFFFF, 32'h0000_0000, 32'd9, 16'd1);
		offer_header(1'b1, cur_tmpl, 32'h0000_0000, 32'd0, 16'd1);
		offer_header(1'b1, cur_tmpl, 32'h0000_0000, 32'd1, 16'hFFFF);
		offer_header(1'b1, cur_tmpl, 32'h0000_0000, 32'd1, 16'd3);
		offer_header(1'b1, cur_tmpl, 32'h0000_0000, 32'd0, 16'd5);
		offer_header(1'b1, cur_tmpl, 32'h0000_0000, 32'd0, 16'd0);
		offer_header(1'b1, cur_tmpl, 32'h0000_0000, 32'd2, 16'hFFFE);
		offer_header(1'b1, cur_tmpl, 32'h0000_0000, 32'd2, 16'd7);
		offer_header(1'b1, cur_tmpl, 32'h7FFF_FFFF, 32'd100, 16'd0);
		offer_header(1'b1, cur_tmpl, 32'h7FFF_FFFF, 32'd1, 16'd9);
		offer_header(1'b1, cur_tmpl, 32'h8000_0000, 32'hFFFF_FFFF, 16'd1);
		offer_header(1'b1, cur_tmpl, 32'h8000_0000, 32'hFFFF_FFFF, 16'd1);
		offer_header(1'b1, cur_tmpl, 32'h8000_0000, 32'hFFFF_FFFE, 16'h8001);
		offer_header(1'b1, cur_tmpl, 32'hFFFF_FFFF, 32'h8000_0000, 16'd11);
		offer_header(1'b1, cur_tmpl, 32'h0000_1234, 32'd7, 16'd13);
		offer_header(1'b0, cur_tmpl, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

		pool_key[0] = 32'h0000_0000;  pool_seq[0] = 32'd2;
		pool_key[1] = 32'h7FFF_FFFF;  pool_seq[1] = 32'd1;
		pool_key[2] = 32'hFFFF_FFFF;  pool_seq[2] = 32'h8000_0000;
		pool_key[3] = 32'h0000_1234;  pool_seq[3] = 32'd7;
		for (int i = 4; i < SEGMENTS; i++) begin
			pool_key[i] = $urandom;
			pool_seq[i] = '0;
		end

		phase_tmpl[0] = 16'h0000;
		phase_tmpl[1] = 16'hFFFF;
		phase_tmpl[2] = 16'($urandom);
		phase_tmpl[3] = TEMPLATE_RESET;
		phase_tmpl[4] = 16'($urandom);

		sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			calm = 1'b0;
			set_template(phase_tmpl[ph]);
			cur_tmpl = phase_tmpl[ph];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				calm = (n < 40);
				roll = $urandom_range(0, 99);
				sub  = $urandom_range(0, 99);
				k    = $urandom_range(0, SEGMENTS - 1);
				port = 16'($urandom);
				if (roll < 6) begin
					offer_header(1'b0, 16'($urandom), $urandom, $urandom, port);
				end else if (roll < 12) begin
					offer_header(1'b1, 16'($urandom), $urandom, $urandom, port);
				end else if (roll < 17 && sent > 150) begin
					offer_header(1'b1, cur_tmpl, $urandom, $urandom, port);
				end else if (sub < 8) begin
					offer_header(1'b1, cur_tmpl, pool_key[k], $urandom,
						{port[15:1], 1'b0});
				end else if (sub < 38) begin
					// same packet seen again on the other feed
					offer_header(1'b1, cur_tmpl, pool_key[k], pool_seq[k],
						{port[15:1], 1'b1});
				end else if (sub < 45) begin
					offer_header(1'b1, cur_tmpl, pool_key[k],
						(pool_seq[k] > 32'd50) ?
							pool_seq[k] - 32'($urandom_range(1, 50)) : 32'd0,
						{port[15:1], 1'b1});
				end else begin
					pool_seq[k] = pool_seq[k] + 32'($urandom_range(1, 4));
					offer_header(1'b1, cur_tmpl, pool_key[k], pool_seq[k],
						{port[15:1], (sub < 90)});
				end
				sent++;
			end
		end

		calm = 1'b0;
		drain_all();
		if (fail_count == 0 && verdicts_owed == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
